FILE: rtl/cdll_pkg.sv
// Shared types and constants for the circular doubly linked list unit.
package cdll_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_DEL_VALUE = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_BACK  = 3'd4;
  localparam logic [2:0] OP_LIST      = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] operand_value;
  } cdll_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element_value;
    logic [5:0]         element_count;
    logic               last_result;
  } cdll_out_t;

endpackage

FILE: rtl/cdll_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cdll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/circular_doubly_linked_list_unit.sv
// Top level: bounded circular doubly linked list with a free-slot stack.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | opcode, operand_value
//  out     | output    | out_valid_o / out_stall_i | status, element_value,
//          |           |                         |   element_count, last_result
//
// Flow: one item at a time. Insert pops a free slot and stores the value,
// writes the links in S_INS_A and S_INS_B (S_INS_A alone into an empty
// list), then gives its result; delete back fetches the tail in S_BACK, then
// unlinks in S_DEL_RD like delete front; flags go straight to S_RESULT.
// Delete by value ends at a match or at the list's end; a listing gives one
// result per element; walks visit one node per cycle via the single read port.
// Reset clears control state and the free-slot stack at once; the value and
// link memories stay undefined and are only read for live nodes.
// A stall on the output holds the walk; a new item is taken only in idle,
// even while the last result still sits in the output register.
module circular_doubly_linked_list_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cdll_pkg::cdll_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cdll_pkg::cdll_out_t out_data_o
);

  import cdll_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_A,
    S_INS_B,
    S_CHK,
    S_BACK,
    S_DEL_RD,
    S_LIST,
    S_RESULT
  } state_e;

  state_e state_q, state_d;

  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] free_top_q, free_top_d;
  logic [CNT_W-1:0] iter_q, iter_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic             front_q, front_d;
  logic [31:0]      opv_q, opv_d;
  logic [1:0]       res_status_q, res_status_d;
  logic [31:0]      res_value_q, res_value_d;
  logic             out_valid_q, out_valid_d;
  cdll_out_t        out_q, out_d;

  // free-slot stack: one read and one write address per cycle
  logic [IDX_W-1:0] stack_q [CAPACITY];
  logic             stack_we;
  logic [IDX_W-1:0] stack_waddr;
  logic [IDX_W-1:0] stack_wdata;

  // link and value memories share one read address
  logic [IDX_W-1:0] raddr;
  logic             val_we, nxt_we, prv_we;
  logic [IDX_W-1:0] val_waddr, nxt_waddr, prv_waddr;
  logic [31:0]      val_wdata, val_rdata;
  logic [IDX_W-1:0] nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;

  logic             out_free;
  logic             do_unlink;
  logic [CNT_W-1:0] iter_inc;
  logic [IDX_W-1:0] pop_addr;

  cdll_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_wdata),
    .raddr_i(raddr),
    .rdata_o(val_rdata)
  );

  cdll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_nxt_ram (
    .clk_i  (clk_i),
    .we_i   (nxt_we),
    .waddr_i(nxt_waddr),
    .wdata_i(nxt_wdata),
    .raddr_i(raddr),
    .rdata_o(nxt_rdata)
  );

  cdll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prv_ram (
    .clk_i  (clk_i),
    .we_i   (prv_we),
    .waddr_i(prv_waddr),
    .wdata_i(prv_wdata),
    .raddr_i(raddr),
    .rdata_o(prv_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign iter_inc = iter_q + CNT_W'(1);
  // top of stack sits one below free_top
  assign pop_addr = IDX_W'(free_top_q - CNT_W'(1));

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    free_top_d   = free_top_q;
    iter_d       = iter_q;
    cur_d        = cur_q;
    idx_d        = idx_q;
    tail_d       = tail_q;
    front_d      = front_q;
    opv_d        = opv_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    raddr        = cur_q;
    val_we       = 1'b0;
    val_waddr    = idx_q;
    val_wdata    = opv_q;
    nxt_we       = 1'b0;
    nxt_waddr    = idx_q;
    nxt_wdata    = head_q;
    prv_we       = 1'b0;
    prv_waddr    = idx_q;
    prv_wdata    = head_q;
    stack_we     = 1'b0;
    stack_waddr  = free_top_q[IDX_W-1:0];
    stack_wdata  = cur_q;
    do_unlink    = 1'b0;

    case (state_q)
      S_IDLE: begin
        // look at the head so the next cycle has its links ready
        raddr = head_q;
        if (in_valid_i) begin
          opv_d        = in_data_i.operand_value;
          front_d      = (in_data_i.opcode == OP_INS_FRONT);
          res_status_d = ST_OK;
          res_value_d  = '0;
          cur_d        = head_q;
          iter_d       = '0;
          if (in_data_i.opcode == OP_INS_FRONT || in_data_i.opcode == OP_INS_BACK) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              res_status_d = ST_FULL;
              state_d      = S_RESULT;
            end else begin
              // pop a free slot and store the value there now
              idx_d      = stack_q[pop_addr];
              free_top_d = free_top_q - CNT_W'(1);
              val_we     = 1'b1;
              val_waddr  = stack_q[pop_addr];
              val_wdata  = in_data_i.operand_value;
              state_d    = S_INS_A;
            end
          end else if (in_data_i.opcode > OP_LIST) begin
            state_d = S_RESULT;
          end else if (count_q == '0) begin
            res_status_d = ST_EMPTY;
            state_d      = S_RESULT;
          end else begin
            case (in_data_i.opcode)
              OP_DEL_VALUE: state_d = S_CHK;
              OP_DEL_FRONT: state_d = S_DEL_RD;
              OP_DEL_BACK:  state_d = S_BACK;
              default:      state_d = S_LIST;
            endcase
          end
        end
      end

      S_INS_A: begin
        if (count_q == '0) begin
          // first node links to itself
          nxt_we    = 1'b1;
          nxt_wdata = idx_q;
          prv_we    = 1'b1;
          prv_wdata = idx_q;
          head_d    = idx_q;
          count_d   = count_q + CNT_W'(1);
          state_d   = S_RESULT;
        end else begin
          // new node sits between tail and head
          nxt_we    = 1'b1;
          nxt_wdata = head_q;
          prv_we    = 1'b1;
          prv_wdata = prv_rdata;
          tail_d    = prv_rdata;
          state_d   = S_INS_B;
        end
      end

      S_INS_B: begin
        nxt_we    = 1'b1;
        nxt_waddr = tail_q;
        nxt_wdata = idx_q;
        prv_we    = 1'b1;
        prv_waddr = head_q;
        prv_wdata = idx_q;
        if (front_q) begin
          head_d = idx_q;
        end
        count_d = count_q + CNT_W'(1);
        state_d = S_RESULT;
      end

      S_BACK: begin
        // tail is the head's predecessor: fetch its node next
        raddr   = prv_rdata;
        cur_d   = prv_rdata;
        state_d = S_DEL_RD;
      end

      S_DEL_RD: begin
        do_unlink = 1'b1;
        state_d   = S_RESULT;
      end

      S_CHK: begin
        if (val_rdata == opv_q) begin
          do_unlink = 1'b1;
          state_d   = S_RESULT;
        end else if (iter_inc == count_q) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_RESULT;
        end else begin
          iter_d = iter_inc;
          cur_d  = nxt_rdata;
          raddr  = nxt_rdata;
        end
      end

      S_LIST: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = ST_OK;
          out_d.element_value = val_rdata;
          out_d.element_count = 6'(count_q);
          out_d.last_result   = (iter_inc == count_q);
          if (iter_inc == count_q) begin
            state_d = S_IDLE;
          end else begin
            iter_d = iter_inc;
            cur_d  = nxt_rdata;
            raddr  = nxt_rdata;
          end
        end
      end

      S_RESULT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = res_status_q;
          out_d.element_value = res_value_q;
          out_d.element_count = 6'(count_q);
          out_d.last_result   = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // unlink the node at cur_q, whose links and value are on the read ports
    if (do_unlink) begin
      nxt_we       = 1'b1;
      nxt_waddr    = prv_rdata;
      nxt_wdata    = nxt_rdata;
      prv_we       = 1'b1;
      prv_waddr    = nxt_rdata;
      prv_wdata    = prv_rdata;
      res_status_d = ST_OK;
      res_value_d  = val_rdata;
      count_d      = count_q - CNT_W'(1);
      if (cur_q == head_q) begin
        head_d = nxt_rdata;
      end
      if (count_q == CNT_W'(1)) begin
        head_d = '0;
      end
      stack_we    = 1'b1;
      stack_waddr = free_top_q[IDX_W-1:0];
      stack_wdata = cur_q;
      free_top_d  = free_top_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      free_top_q  <= CNT_W'(CAPACITY);
      out_valid_q <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        stack_q[i] <= IDX_W'(i);
      end
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      free_top_q  <= free_top_d;
      out_valid_q <= out_valid_d;
      if (stack_we) begin
        stack_q[stack_waddr] <= stack_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q       <= iter_d;
    cur_q        <= cur_d;
    idx_q        <= idx_d;
    tail_q       <= tail_d;
    front_q      <= front_d;
    opv_q        <= opv_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_q        <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // between items every slot is either on the free stack or in the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((free_top_q + count_q) == CNT_W'(CAPACITY)))
    else $error("free stack and node count out of step");

  // an empty list keeps its head at slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0))
    else $error("empty list with nonzero head");

  // a listing walk only runs over a non-empty list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> (count_q != '0) && (iter_q < count_q))
    else $error("listing walk beyond the list");

  // a result with last set ends the item and returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && out_valid_d && state_d == S_IDLE)
      |=> out_data_o.last_result)
    else $error("item finished without a final result");

endmodule
